>>> hdl/cst_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cycle signature table package
// Shared types, constants and helpers for the cycle signature table.
// ----------------------------------------------------------------------------
package cst_pkg;

    // Default sizes of the table and of one signature.
    localparam int TABLE_ENTRIES_DEF = 32;
    localparam int MAX_HOPS_DEF      = 8;

    // A signature with fewer pairs than this is ignored.
    localparam int MIN_PAIRS = 2;

    // Field widths of the item channels.
    localparam int TID_W   = 32;
    localparam int ADDR_W  = 64;
    localparam int TIME_W  = 64;
    localparam int COUNT_W = 32;
    localparam int SLOT_W  = 5;

    // Operation codes carried on the closing item.
    localparam logic OP_OBSERVE = 1'b0;
    localparam logic OP_CONFIRM = 1'b1;

    // One (thread id, lock address) pair.
    typedef struct packed {
        logic [TID_W-1:0]  tid;
        logic [ADDR_W-1:0] addr;
    } t_pair;

    // Per-entry bookkeeping kept in the metadata memory.
    typedef struct packed {
        logic [TIME_W-1:0]  first_seen;
        logic [TIME_W-1:0]  last_seen;
        logic [COUNT_W-1:0] observations;
    } t_meta;

    // One result item.
    typedef struct packed {
        logic               ignored;
        logic               found;
        logic               fresh_entry;
        logic [SLOT_W-1:0]  slot;
        logic [COUNT_W-1:0] observation_count;
        logic [TIME_W-1:0]  age_ms;
    } t_result;

    // Sequencer states.
    typedef enum logic [3:0] {
        S_IDLE,
        S_LOOK_CHK,
        S_LOOK_CMP,
        S_META_RD,
        S_META_UPD,
        S_FREE,
        S_VICT,
        S_COPY,
        S_INSERT,
        S_FINISH
    } t_state;

    // Ordering of pairs: by thread id, then by lock address.
    function automatic logic pair_less(input t_pair a, input t_pair b);
        logic res;
        if (a.tid != b.tid) begin
            res = (a.tid < b.tid);
        end else begin
            res = (a.addr < b.addr);
        end
        return res;
    endfunction

endpackage

>>> hdl/cst_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cycle signature table channels
// Valid/ready channels for pair items in and result items out.
// ----------------------------------------------------------------------------

// Pair items into the table.
interface cst_req_if;
    logic                       valid;
    logic                       ready;
    logic                       op;
    logic [cst_pkg::TID_W-1:0]  thread_id;
    logic [cst_pkg::ADDR_W-1:0] lock_ptr;
    logic                       last_pair;
    logic [cst_pkg::TIME_W-1:0] now_ms;

    modport source (output valid, output op, output thread_id, output lock_ptr,
                    output last_pair, output now_ms, input ready);
    modport sink   (input valid, input op, input thread_id, input lock_ptr,
                    input last_pair, input now_ms, output ready);
endinterface

// Result items out of the table.
interface cst_rsp_if;
    logic                        valid;
    logic                        ready;
    logic                        ignored;
    logic                        found;
    logic                        fresh_entry;
    logic [cst_pkg::SLOT_W-1:0]  slot;
    logic [cst_pkg::COUNT_W-1:0] observation_count;
    logic [cst_pkg::TIME_W-1:0]  age_ms;

    modport source (output valid, output ignored, output found,
                    output fresh_entry, output slot,
                    output observation_count, output age_ms, input ready);
    modport sink   (input valid, input ignored, input found,
                    input fresh_entry, input slot,
                    input observation_count, input age_ms, output ready);
endinterface

>>> hdl/cycle_signature_table_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cycle signature table core
// Collects wait-cycle signatures and observes or confirms them in a table.
// ----------------------------------------------------------------------------
// Pair items arrive one per cycle while the sequencer is idle and the
// output register is free, and are insertion-sorted into an assembly
// buffer in the cycle they are accepted, as long as it holds fewer than
// MAX_HOPS pairs; only the item with last_pair set produces a result item.
// That closing item starts a sequencer built around one pair memory read
// port and one 96-bit compare: the lookup checks the length of each entry
// and, where it matches, compares the stored pairs one by one until one
// differs or all match. A hit then reads and updates the metadata. An
// observe miss picks a free slot, or scans last-seen times when the table
// is full, then copies the pairs one by one and commits the entry; a
// confirm miss goes straight to the finish state, which hands the result
// to the output register. A short cycle (fewer than two pairs) is answered
// in the cycle after it is accepted. The table is empty right after reset.
// ----------------------------------------------------------------------------
module cycle_signature_table_core #(
    parameter int TABLE_ENTRIES = cst_pkg::TABLE_ENTRIES_DEF,
    parameter int MAX_HOPS      = cst_pkg::MAX_HOPS_DEF
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    cst_req_if.sink   i_req,
    cst_rsp_if.source o_rsp
);

    localparam int EW     = $clog2(TABLE_ENTRIES);
    localparam int HW     = $clog2(MAX_HOPS);
    localparam int CW     = $clog2(MAX_HOPS + 1);
    localparam int PAIR_W = $bits(cst_pkg::t_pair);
    localparam int META_W = $bits(cst_pkg::t_meta);

    // Sequencer and control state.
    cst_pkg::t_state r_state, n_state;
    logic [EW:0]     r_e;
    logic [HW-1:0]   r_h;
    logic [CW-1:0]   r_cnt;
    logic            r_op;
    logic [cst_pkg::TIME_W-1:0] r_now;
    logic [EW-1:0]   r_slot;

    // Victim scan.
    logic [EW:0]     r_vidx;
    logic            r_vcmp;
    logic [EW-1:0]   r_vcmp_idx;
    logic [EW-1:0]   r_best;
    logic [cst_pkg::TIME_W-1:0] r_best_ls;

    // Per-entry flags and lengths.
    logic            r_valid [TABLE_ENTRIES];
    logic            r_conf  [TABLE_ENTRIES];
    logic [CW-1:0]   r_len   [TABLE_ENTRIES];

    // Assembly buffer, kept sorted.
    cst_pkg::t_pair  r_asm [MAX_HOPS];
    cst_pkg::t_pair  n_asm [MAX_HOPS];

    // Staged and presented results.
    cst_pkg::t_result r_res;
    cst_pkg::t_result r_out;
    logic             r_out_valid;

    // Memory ports.
    logic                 pair_we;
    logic [EW+HW-1:0]     pair_waddr;
    logic [PAIR_W-1:0]    pair_wdata;
    logic [EW+HW-1:0]     pair_raddr;
    logic [PAIR_W-1:0]    pair_rdata;
    logic                 meta_we;
    logic [EW-1:0]        meta_waddr;
    logic [META_W-1:0]    meta_wdata;
    logic [EW-1:0]        meta_raddr;
    logic [META_W-1:0]    meta_rdata;

    // Datapath helpers.
    logic            accept;
    logic            do_add;
    logic [CW-1:0]   cnt_add;
    logic            short_cycle;
    logic            short_close;
    cst_pkg::t_pair  in_pair;
    logic [MAX_HOPS-1:0] lt;
    logic [EW-1:0]   e_idx;
    logic            len_match;
    logic            pair_match;
    logic            last_hop;
    cst_pkg::t_meta  m_rd;
    logic [cst_pkg::COUNT_W-1:0] obs_inc;
    logic [cst_pkg::TIME_W-1:0]  age;
    logic            all_valid;
    logic [EW-1:0]   first_free;
    logic            vict_take;
    logic [EW-1:0]   vict_pick;
    logic            vict_done;
    logic            out_free;
    logic            out_load;
    cst_pkg::t_result ign_res;

    cst_ram #(.WIDTH(PAIR_W), .DEPTH(2 ** (EW + HW))) u_pair_ram (
        .i_clk   (i_clk),
        .i_we    (pair_we),
        .i_waddr (pair_waddr),
        .i_wdata (pair_wdata),
        .i_raddr (pair_raddr),
        .o_rdata (pair_rdata)
    );

    cst_ram #(.WIDTH(META_W), .DEPTH(2 ** EW)) u_meta_ram (
        .i_clk   (i_clk),
        .i_we    (meta_we),
        .i_waddr (meta_waddr),
        .i_wdata (meta_wdata),
        .i_raddr (meta_raddr),
        .o_rdata (meta_rdata)
    );

    // Handshake and assembly count after the incoming pair.
    assign out_free    = !r_out_valid || o_rsp.ready;
    assign accept      = i_req.valid && i_req.ready;
    assign do_add      = (r_cnt < CW'(MAX_HOPS));
    assign cnt_add     = do_add ? r_cnt + CW'(1) : r_cnt;
    assign short_cycle = (cnt_add < CW'(cst_pkg::MIN_PAIRS));
    assign short_close = i_req.last_pair && short_cycle;
    assign in_pair.tid  = i_req.thread_id;
    assign in_pair.addr = i_req.lock_ptr;

    // The output register loads on a short cycle or at the end of a sequence.
    assign out_load = ((r_state == cst_pkg::S_IDLE) && accept && short_close)
                   || ((r_state == cst_pkg::S_FINISH) && out_free);

    // Result of an ignored cycle: only the ignored flag is set.
    always_comb begin
        ign_res         = '0;
        ign_res.ignored = 1'b1;
    end

    // Sorted insertion: pairs greater than the new one move up one place.
    always_comb begin
        for (int i = 0; i < MAX_HOPS; i++) begin
            lt[i] = cst_pkg::pair_less(in_pair, r_asm[i]);
        end
        for (int i = 0; i < MAX_HOPS; i++) begin
            n_asm[i] = r_asm[i];
            if ((CW'(i) < r_cnt && lt[i]) || CW'(i) == r_cnt) begin
                if (i > 0 && lt[(i > 0) ? i - 1 : 0]) begin
                    n_asm[i] = r_asm[(i > 0) ? i - 1 : 0];
                end else begin
                    n_asm[i] = in_pair;
                end
            end
        end
    end

    // Lookup compare.
    assign e_idx      = r_e[EW-1:0];
    assign len_match  = r_valid[e_idx] && (r_len[e_idx] == r_cnt);
    assign pair_match = (cst_pkg::t_pair'(pair_rdata) == r_asm[r_h]);
    assign last_hop   = (CW'(r_h) == r_cnt - CW'(1));

    // Metadata update for a hit.
    assign m_rd    = cst_pkg::t_meta'(meta_rdata);
    assign obs_inc = (&m_rd.observations) ? m_rd.observations
                                          : m_rd.observations + 1'b1;
    assign age     = (r_now >= m_rd.first_seen) ? r_now - m_rd.first_seen : '0;

    // First free slot, lowest index first.
    always_comb begin
        all_valid  = 1'b1;
        first_free = '0;
        for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
            if (!r_valid[i]) begin
                all_valid  = 1'b0;
                first_free = EW'(i);
            end
        end
    end

    // Least last-seen time, lowest index on a tie.
    assign vict_take = (r_vcmp_idx == '0) || (m_rd.last_seen < r_best_ls);
    assign vict_pick = vict_take ? r_vcmp_idx : r_best;
    assign vict_done = r_vcmp && (r_vcmp_idx == EW'(TABLE_ENTRIES - 1));

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            cst_pkg::S_IDLE: begin
                if (accept && i_req.last_pair && !short_cycle) begin
                    n_state = cst_pkg::S_LOOK_CHK;
                end
            end
            cst_pkg::S_LOOK_CHK: begin
                if (r_e == (EW + 1)'(TABLE_ENTRIES)) begin
                    n_state = (r_op == cst_pkg::OP_OBSERVE) ? cst_pkg::S_FREE
                                                            : cst_pkg::S_FINISH;
                end else if (len_match) begin
                    n_state = cst_pkg::S_LOOK_CMP;
                end
            end
            cst_pkg::S_LOOK_CMP: begin
                if (!pair_match) begin
                    n_state = cst_pkg::S_LOOK_CHK;
                end else if (last_hop) begin
                    n_state = cst_pkg::S_META_RD;
                end
            end
            cst_pkg::S_META_RD:  n_state = cst_pkg::S_META_UPD;
            cst_pkg::S_META_UPD: n_state = cst_pkg::S_FINISH;
            cst_pkg::S_FREE: begin
                n_state = all_valid ? cst_pkg::S_VICT : cst_pkg::S_COPY;
            end
            cst_pkg::S_VICT: begin
                if (vict_done) begin
                    n_state = cst_pkg::S_COPY;
                end
            end
            cst_pkg::S_COPY: begin
                if (last_hop) begin
                    n_state = cst_pkg::S_INSERT;
                end
            end
            cst_pkg::S_INSERT: n_state = cst_pkg::S_FINISH;
            cst_pkg::S_FINISH: begin
                if (out_free) begin
                    n_state = cst_pkg::S_IDLE;
                end
            end
            default: n_state = cst_pkg::S_IDLE;
        endcase
    end

    // Outputs of the sequencer: handshake and memory ports.
    always_comb begin
        i_req.ready = 1'b0;
        pair_we     = 1'b0;
        pair_waddr  = {r_slot, r_h};
        pair_wdata  = r_asm[r_h];
        pair_raddr  = {e_idx, r_h + HW'(1)};
        meta_we     = 1'b0;
        meta_waddr  = r_slot;
        meta_wdata  = {m_rd.first_seen, r_now, obs_inc};
        meta_raddr  = r_slot;
        unique case (r_state)
            cst_pkg::S_IDLE:     i_req.ready = out_free;
            cst_pkg::S_LOOK_CHK: pair_raddr  = {e_idx, HW'(0)};
            cst_pkg::S_META_UPD: meta_we     = (r_op == cst_pkg::OP_OBSERVE);
            cst_pkg::S_VICT:     meta_raddr  = r_vidx[EW-1:0];
            cst_pkg::S_COPY:     pair_we     = 1'b1;
            cst_pkg::S_INSERT: begin
                meta_we    = 1'b1;
                meta_wdata = {r_now, r_now, cst_pkg::COUNT_W'(1)};
            end
            default: ;
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= cst_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Sequenced datapath and table flags.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < TABLE_ENTRIES; i++) begin
                r_valid[i] <= 1'b0;
                r_conf[i]  <= 1'b0;
                r_len[i]   <= '0;
            end
        end else begin
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                cst_pkg::S_IDLE: begin
                    if (accept) begin
                        if (do_add) begin
                            r_asm <= n_asm;
                        end
                        r_cnt <= short_close ? '0 : cnt_add;
                        r_op  <= i_req.op;
                        r_now <= i_req.now_ms;
                        r_e   <= '0;
                        r_h   <= '0;
                        if (short_close) begin
                            r_out <= ign_res;
                        end
                    end
                end
                cst_pkg::S_LOOK_CHK: begin
                    r_h <= '0;
                    r_res <= '0;
                    if (r_e != (EW + 1)'(TABLE_ENTRIES) && !len_match) begin
                        r_e <= r_e + 1'b1;
                    end
                    r_vidx <= '0;
                    r_vcmp <= 1'b0;
                end
                cst_pkg::S_LOOK_CMP: begin
                    if (!pair_match) begin
                        r_e <= r_e + 1'b1;
                    end else if (last_hop) begin
                        r_slot <= e_idx;
                    end else begin
                        r_h <= r_h + 1'b1;
                    end
                end
                cst_pkg::S_META_UPD: begin
                    r_res.found  <= 1'b1;
                    r_res.slot   <= cst_pkg::SLOT_W'(r_slot);
                    r_res.age_ms <= age;
                    if (r_op == cst_pkg::OP_OBSERVE) begin
                        r_res.observation_count <= obs_inc;
                    end else begin
                        r_res.observation_count <= m_rd.observations;
                        r_conf[r_slot] <= 1'b1;
                    end
                end
                cst_pkg::S_FREE: begin
                    r_h    <= '0;
                    r_slot <= first_free;
                end
                cst_pkg::S_VICT: begin
                    if (r_vidx != (EW + 1)'(TABLE_ENTRIES)) begin
                        r_vidx <= r_vidx + 1'b1;
                    end
                    r_vcmp     <= (r_vidx != (EW + 1)'(TABLE_ENTRIES));
                    r_vcmp_idx <= r_vidx[EW-1:0];
                    if (r_vcmp) begin
                        r_best    <= vict_pick;
                        r_best_ls <= vict_take ? m_rd.last_seen : r_best_ls;
                    end
                    if (vict_done) begin
                        r_slot <= vict_pick;
                    end
                end
                cst_pkg::S_COPY: begin
                    if (!last_hop) begin
                        r_h <= r_h + 1'b1;
                    end
                end
                cst_pkg::S_INSERT: begin
                    r_valid[r_slot] <= 1'b1;
                    r_conf[r_slot]  <= 1'b0;
                    r_len[r_slot]   <= r_cnt;
                    r_res.fresh_entry       <= 1'b1;
                    r_res.slot              <= cst_pkg::SLOT_W'(r_slot);
                    r_res.observation_count <= cst_pkg::COUNT_W'(1);
                    r_res.age_ms            <= '0;
                end
                cst_pkg::S_FINISH: begin
                    if (out_free) begin
                        r_out <= r_res;
                        r_cnt <= '0;
                    end
                end
                default: ;
            endcase
        end
    end

    // Result channel.
    assign o_rsp.valid             = r_out_valid;
    assign o_rsp.ignored           = r_out.ignored;
    assign o_rsp.found             = r_out.found;
    assign o_rsp.fresh_entry       = r_out.fresh_entry;
    assign o_rsp.slot              = r_out.slot;
    assign o_rsp.observation_count = r_out.observation_count;
    assign o_rsp.age_ms            = r_out.age_ms;

    // An ignored cycle reports nothing else.
    a_ignored_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.ignored) |-> (!o_rsp.found && !o_rsp.fresh_entry
            && o_rsp.observation_count == '0 && o_rsp.age_ms == '0))
        else $error("ignored result carries data");

    // A result is never both a hit and a fresh insert.
    a_found_xor_new: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid |-> !(o_rsp.found && o_rsp.fresh_entry))
        else $error("found and fresh entry both set");

    // A fresh insert starts with one observation and zero age.
    a_new_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.fresh_entry)
            |-> (o_rsp.observation_count == 1 && o_rsp.age_ms == '0))
        else $error("fresh entry with wrong count or age");

    // The assembly count never passes the hop limit.
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(MAX_HOPS))
        else $error("assembly count overflow");

endmodule

>>> hdl/cst_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cycle signature table RAM
// Simple dual-port memory, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module cst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
